>>> sv/rhstp_pkg.sv
// Shared types, constants and a helper function for the record header parser.
`default_nettype none
package rhstp_pkg;

    localparam int unsigned OFF_W = 17;
    localparam logic [OFF_W-1:0] OFF_MAX = 17'h1ffff;

    // Column count clamp
    localparam logic [6:0] MAX_COLUMNS = 7'd64;

    // Fixed header fields before the column serial types
    localparam logic [6:0] FIELD_PAYLOAD_LEN = 7'd0;
    localparam logic [6:0] FIELD_ROW_ID      = 7'd1;
    localparam logic [6:0] FIELD_FIRST_COL   = 7'd3;

    // Varint coding
    localparam int unsigned VARINT_CONT_BIT  = 7;
    localparam logic [3:0]  VARINT_LAST_BYTE = 4'd8;

    // Serial types
    localparam logic [31:0] ST_INT32      = 32'd4;
    localparam logic [31:0] ST_FLOAT      = 32'd7;
    localparam logic [31:0] ST_VAR_BASE   = 32'd12;
    localparam logic [7:0]  ST_ENC_INT32  = 8'd10;
    localparam logic [7:0]  ST_ENC_FLOAT  = 8'd11;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] CFG_ENCRYPT_MASK = 2'd1;

    typedef struct packed {
        logic [6:0]  column_count;
        logic [63:0] encrypt_mask;
    } rhstp_cfg_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             header_done;
        logic [31:0]      payload_length;
        logic [31:0]      row_id;
        logic [OFF_W-1:0] data_start;
        logic [OFF_W-1:0] data_end_excl;
        logic             overflow;
    } rhstp_result_t;

    // Column body size in bytes for a serial type
    function automatic logic [31:0] serial_size(input logic [31:0] t);
        logic [31:0] sz;
        begin
            if (t < ST_VAR_BASE)
            begin
                unique case (t[3:0])
                    4'd0:    sz = 32'd0;
                    4'd1:    sz = 32'd1;
                    4'd2:    sz = 32'd2;
                    4'd3:    sz = 32'd3;
                    4'd4:    sz = 32'd4;
                    4'd5:    sz = 32'd6;
                    4'd6:    sz = 32'd8;
                    4'd7:    sz = 32'd8;
                    default: sz = 32'd0;
                endcase
            end
            else
            begin
                // (t-12)/2 for even, (t-13)/2 for odd: both are t/2 - 6
                sz = {1'b0, t[31:1]} - (ST_VAR_BASE >> 1);
            end
            return sz;
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/record_header_serial_type_parser.sv
// Top level: record header varint parser with serial type rewrite.
// Path from input accept to result valid: input register, then result register.
// One item per cycle unless out_ready stalls; the header state loop is combinational.
// Results may wait in the result register while the next item is taken in.
// Reset (rst_n low, async): both pipeline registers empty, parse idle, config cleared.
// After reset, bytes pass through unchanged until an item with first_byte set.
`default_nettype none
module record_header_serial_type_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // input byte channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        first_byte,
    input  wire logic [15:0] cell_offset,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             header_done,
    output logic [31:0]      payload_length,
    output logic [31:0]      row_id,
    output logic [16:0]      data_start,
    output logic [16:0]      data_end_excl,
    output logic             overflow
);
    import rhstp_pkg::*;

    rhstp_cfg_t    cfg;
    rhstp_result_t result;
    rhstp_result_t held;

    // Input register stage
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_first_reg;
    logic [15:0] s1_offset_reg;

    logic in_take;
    logic s1_adv;

    // The stage-1 item moves into the result register (and commits its
    // parse state update) whenever the result register is free or drains.
    assign s1_adv   = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg   <= in_byte;
            s1_first_reg  <= first_byte;
            s1_offset_reg <= cell_offset;
        end
    end

    rhstp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Varint decode, column sizing and rewrite; state commits on s1_adv
    rhstp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (s1_adv),
        .in_byte     (s1_byte_reg),
        .first_byte  (s1_first_reg),
        .cell_offset (s1_offset_reg),
        .cfg         (cfg),
        .result      (result)
    );

    rhstp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_adv),
        .result    (result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .held      (held)
    );

    assign out_byte       = held.out_byte;
    assign header_done    = held.header_done;
    assign payload_length = held.payload_length;
    assign row_id         = held.row_id;
    assign data_start     = held.data_start;
    assign data_end_excl  = held.data_end_excl;
    assign overflow       = held.overflow;

    // Empty result register never stalls the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // Data end never precedes data start
    a_end_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && header_done) |-> (data_end_excl >= data_start))
        else $error("data end before data start");

    // Header fields are zero on bytes that do not complete a header
    a_zero_without_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !header_done) |->
            (payload_length == '0 && row_id == '0 && data_start == '0 &&
             data_end_excl == '0 && !overflow))
        else $error("header fields set without header completion");

    // Stage 1 keeps holding an item until it moves on
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stage-1 item lost");

endmodule
`default_nettype wire

>>> sv/rhstp_cfg_regs.sv
// Configuration registers: column count and encryption column mask.
`default_nettype none
module rhstp_cfg_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_data,
    output rhstp_pkg::rhstp_cfg_t  cfg
);
    import rhstp_pkg::*;

    logic [6:0]  column_count_reg;
    logic [63:0] encrypt_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            encrypt_mask_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data[6:0];
                CFG_ENCRYPT_MASK: encrypt_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.column_count = column_count_reg;
    assign cfg.encrypt_mask = encrypt_mask_reg;

endmodule
`default_nettype wire

>>> sv/rhstp_parser.sv
// Header parse state and per-byte next-state / result logic.
`default_nettype none
module rhstp_parser (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 first_byte,
    input  wire logic [15:0]          cell_offset,
    input  wire rhstp_pkg::rhstp_cfg_t cfg,
    output rhstp_pkg::rhstp_result_t  result
);
    import rhstp_pkg::*;

    logic [6:0]       fidx_reg,   fidx_next;
    logic [3:0]       vbytes_reg, vbytes_next;
    logic [31:0]      vval_reg,   vval_next;
    logic [OFF_W-1:0] pos_reg,    pos_next;
    logic [31:0]      plen_reg,   plen_next;
    logic [31:0]      rid_reg,    rid_next;
    logic [OFF_W-1:0] sum_reg,    sum_next;
    logic             sat_reg,    sat_next;
    logic             in_hdr_reg, in_hdr_next;

    // State as seen by this byte (a first byte restarts the parse)
    logic             e_hdr;
    logic [6:0]       e_fidx;
    logic [3:0]       e_vbytes;
    logic [31:0]      e_vval;
    logic [OFF_W-1:0] e_pos;
    logic [31:0]      e_plen;
    logic [31:0]      e_rid;
    logic [OFF_W-1:0] e_sum;
    logic             e_sat;

    logic             last, single, done;
    logic [31:0]      v;
    logic [31:0]      col_size;
    logic [32:0]      sum_wide;
    logic [OFF_W:0]   end_wide;
    logic [OFF_W-1:0] end_off;
    logic [6:0]       cc;
    logic [6:0]       fidx_inc;
    logic [5:0]       col;
    logic [7:0]       outb;

    always_comb
    begin
        e_hdr    = first_byte | in_hdr_reg;
        e_fidx   = first_byte ? '0 : fidx_reg;
        e_vbytes = first_byte ? '0 : vbytes_reg;
        e_vval   = first_byte ? '0 : vval_reg;
        e_pos    = first_byte ? {1'b0, cell_offset} : pos_reg;
        e_plen   = first_byte ? '0 : plen_reg;
        e_rid    = first_byte ? '0 : rid_reg;
        e_sum    = first_byte ? '0 : sum_reg;
        e_sat    = first_byte ? 1'b0 : sat_reg;

        cc = (cfg.column_count > MAX_COLUMNS) ? MAX_COLUMNS : cfg.column_count;

        last   = !in_byte[VARINT_CONT_BIT] || (e_vbytes >= VARINT_LAST_BYTE);
        single = (e_vbytes == 4'd0) && !in_byte[VARINT_CONT_BIT];
        // ninth byte contributes all eight bits
        if (e_vbytes >= VARINT_LAST_BYTE)
            v = {e_vval[23:0], in_byte};
        else
            v = {e_vval[24:0], in_byte[6:0]};

        col_size = serial_size(v);
        col      = 6'(e_fidx - FIELD_FIRST_COL);
        fidx_inc = e_fidx + 7'd1;

        fidx_next   = e_fidx;
        vbytes_next = e_vbytes;
        vval_next   = e_vval;
        plen_next   = e_plen;
        rid_next    = e_rid;
        sum_next    = e_sum;
        sat_next    = e_sat;
        pos_next    = e_pos;
        in_hdr_next = e_hdr;
        outb        = in_byte;
        done        = 1'b0;
        sum_wide    = '0;
        end_wide    = '0;
        end_off     = '0;

        if (e_hdr)
        begin
            if (last)
            begin
                priority if (e_fidx == FIELD_PAYLOAD_LEN)
                begin
                    plen_next = v;
                end
                else if (e_fidx == FIELD_ROW_ID)
                begin
                    rid_next = v;
                end
                else if (e_fidx >= FIELD_FIRST_COL)
                begin
                    sum_wide = {16'd0, e_sum} + {1'b0, col_size};
                    if (sum_wide > {16'd0, OFF_MAX})
                    begin
                        sum_next = OFF_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_wide[OFF_W-1:0];
                    end
                    if (single && cfg.encrypt_mask[col])
                    begin
                        if (v == ST_INT32)
                            outb = ST_ENC_INT32;
                        else if (v == ST_FLOAT)
                            outb = ST_ENC_FLOAT;
                    end
                end
                else
                begin
                    // unused third varint
                end
                fidx_next   = fidx_inc;
                vbytes_next = '0;
                vval_next   = '0;
                done = {1'b0, fidx_inc} >= ({1'b0, FIELD_FIRST_COL} + {1'b0, cc});
            end
            else
            begin
                vbytes_next = e_vbytes + 4'd1;
                vval_next   = v;
            end

            if (e_pos == OFF_MAX)
                sat_next = 1'b1;
            else
                pos_next = e_pos + 17'd1;

            if (done)
            begin
                end_wide = {1'b0, pos_next} + {1'b0, sum_next};
                if (end_wide > {1'b0, OFF_MAX})
                begin
                    end_off  = OFF_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    end_off = end_wide[OFF_W-1:0];
                end
                in_hdr_next = 1'b0;
            end
        end

        result.out_byte       = outb;
        result.header_done    = done;
        result.payload_length = done ? plen_next : '0;
        result.row_id         = done ? rid_next : '0;
        result.data_start     = done ? pos_next : '0;
        result.data_end_excl  = done ? end_off : '0;
        result.overflow       = done & sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fidx_reg   <= '0;
            vbytes_reg <= '0;
            vval_reg   <= '0;
            pos_reg    <= '0;
            plen_reg   <= '0;
            rid_reg    <= '0;
            sum_reg    <= '0;
            sat_reg    <= 1'b0;
            in_hdr_reg <= 1'b0;
        end
        else if (adv)
        begin
            fidx_reg   <= fidx_next;
            vbytes_reg <= vbytes_next;
            vval_reg   <= vval_next;
            pos_reg    <= pos_next;
            plen_reg   <= plen_next;
            rid_reg    <= rid_next;
            sum_reg    <= sum_next;
            sat_reg    <= sat_next;
            in_hdr_reg <= in_hdr_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/rhstp_out_reg.sv
// Result register with valid/ready toward the consumer.
`default_nettype none
module rhstp_out_reg (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire rhstp_pkg::rhstp_result_t result,
    input  wire logic                    out_ready,
    output logic                         out_valid,
    output rhstp_pkg::rhstp_result_t     held
);
    import rhstp_pkg::*;

    logic          valid_reg, valid_next;
    rhstp_result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule
`default_nettype wire
